// ===== rtl/core/scp_pkg.sv =====
// ============================================================================
// scp_pkg
// Shared widths, constants and types of the scan polar-to-Cartesian converter.
// ============================================================================
package scp_pkg;

    // Field widths of the ports.
    localparam int IDX_W     = 12;
    localparam int RANGE_W   = 24;
    localparam int OUT_W     = 25;
    localparam int ANG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd1;

    // Scan size; the sample index is reduced modulo this value.
    localparam int MAX_SAMPLES = 4096;

    // Default and maximum number of CORDIC iterations.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_STAGES_MAX = 30;

    // Modulo by a constant through a reciprocal multiply. With a 24-bit shift
    // and a rounded-up reciprocal the quotient is exact for 12-bit indexes.
    localparam int MOD_SHIFT   = 24;
    localparam int MOD_RECIP_W = 21;
    localparam int MOD_DIV_W   = 17;
    localparam int Q_W         = IDX_W + MOD_RECIP_W - MOD_SHIFT;
    localparam logic [MOD_RECIP_W-1:0] MOD_RECIP =
        MOD_RECIP_W'(((1 << MOD_SHIFT) + MAX_SAMPLES - 1) / MAX_SAMPLES);
    localparam logic [MOD_DIV_W-1:0] MOD_DIV = MOD_DIV_W'(MAX_SAMPLES);

    // CORDIC gain compensation, Q30, and the guard fraction bits.
    localparam int GAIN_W     = 30;
    localparam int GUARD_BITS = 16;
    localparam int GAIN_FRAC  = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'h26DD3B6A;
    localparam int RK_W  = RANGE_W + GAIN_W;
    localparam int X0_W  = RK_W + 1 - (GAIN_FRAC - GUARD_BITS);

    // Datapath widths: x/y carry 16 guard bits and two bits of headroom.
    localparam int XY_W = 42;
    localparam int Z_W  = 34;

    // Angle thresholds in binary angle units.
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = 32'sh4000_0000;
    localparam logic signed [ANG_W-1:0] ANG_NEG_QUARTER = -32'sh4000_0000;
    localparam logic signed [Z_W-1:0]   Z_HALF = 34'sh0_8000_0000;

    // Payload of an item inside the CORDIC pipeline.
    typedef struct packed {
        logic                   kept;
        logic                   scan_end;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // Arc-tangent of 2^-i in binary angle units, rounded to nearest.
    function automatic logic [ANG_W-1:0] atan_turn(input int unsigned i);
        logic [ANG_W-1:0] a;
        case (i)
            0:       a = 32'h20000000;
            1:       a = 32'h12E4051E;
            2:       a = 32'h09FB385B;
            3:       a = 32'h051111D4;
            4:       a = 32'h028B0D43;
            5:       a = 32'h0145D7E1;
            6:       a = 32'h00A2F61E;
            7:       a = 32'h00517C55;
            8:       a = 32'h0028BE53;
            9:       a = 32'h00145F2F;
            10:      a = 32'h000A2F98;
            11:      a = 32'h000517CC;
            12:      a = 32'h00028BE6;
            13:      a = 32'h000145F3;
            14:      a = 32'h0000A2FA;
            15:      a = 32'h0000517D;
            16:      a = 32'h000028BE;
            17:      a = 32'h0000145F;
            18:      a = 32'h00000A30;
            19:      a = 32'h00000518;
            20:      a = 32'h0000028C;
            21:      a = 32'h00000146;
            22:      a = 32'h000000A3;
            23:      a = 32'h00000051;
            24:      a = 32'h00000029;
            25:      a = 32'h00000014;
            26:      a = 32'h0000000A;
            27:      a = 32'h00000005;
            28:      a = 32'h00000003;
            29:      a = 32'h00000001;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/scp_prep.sv =====
// ============================================================================
// scp_prep
// Front pipeline: index reduction, sample angle, gain-scaled start vector and
// quadrant fold into the CORDIC convergence range. Four register stages.
// ============================================================================
module scp_prep
    import scp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [IDX_W-1:0]   sample_index,
    input  logic [RANGE_W-1:0] range_value,
    input  logic               range_finite,
    input  logic               scan_end_in,
    input  logic [ANG_W-1:0]   start_angle,
    input  logic [ANG_W-1:0]   angle_step,
    output logic               out_valid,
    output cordic_t            out_data
);

    // Stage 0: quotient estimate and range times gain.
    logic                          v0_reg;
    logic [IDX_W-1:0]              s0_reg;
    logic [Q_W-1:0]                q0_reg;
    logic [RK_W-1:0]               rk0_reg;
    logic                          kept0_reg;
    logic                          end0_reg;
    logic [IDX_W+MOD_RECIP_W-1:0]  quot_prod;
    logic [RK_W-1:0]               rk0_next;

    // Stage 1: reduced index and rounded start vector.
    logic                          v1_reg;
    logic [IDX_W-1:0]              idx1_reg;
    logic [X0_W-1:0]               x01_reg;
    logic                          kept1_reg;
    logic                          end1_reg;
    logic [Q_W+MOD_DIV_W-1:0]      qm;
    logic [IDX_W-1:0]              idx1_next;
    logic [RK_W:0]                 x0_sum;

    // Stage 2: index times angle step.
    logic                          v2_reg;
    logic [ANG_W-1:0]              prod2_reg;
    logic [X0_W-1:0]               x02_reg;
    logic                          kept2_reg;
    logic                          end2_reg;
    logic [IDX_W+ANG_W-1:0]        ang_prod;

    // Stage 3: angle and fold.
    logic                          v3_reg;
    cordic_t                       d3_reg;
    cordic_t                       d3_next;
    logic signed [ANG_W-1:0]       ang_sum;
    logic signed [Z_W-1:0]         ang_ext;
    logic signed [XY_W-1:0]        x0_ext;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 0 arithmetic.
    assign quot_prod = sample_index * MOD_RECIP;
    assign rk0_next  = range_value * GAIN_Q30;

    // Stage 1 arithmetic: remainder and rounding of r*K to guard precision.
    assign qm        = q0_reg * MOD_DIV;
    assign idx1_next = s0_reg - qm[IDX_W-1:0];
    assign x0_sum    = {1'b0, rk0_reg} + (RK_W+1)'(1 << (GAIN_FRAC - GUARD_BITS - 1));

    // Stage 2 arithmetic: product wraps modulo a full turn.
    assign ang_prod = idx1_reg * angle_step;

    // Stage 3: sample angle and fold by half a turn outside +-1/4 turn.
    assign ang_sum = $signed(start_angle + prod2_reg);
    assign ang_ext = Z_W'(ang_sum);
    assign x0_ext  = $signed({{(XY_W-X0_W){1'b0}}, x02_reg});

    always_comb
    begin
        d3_next.kept     = kept2_reg;
        d3_next.scan_end = end2_reg;
        d3_next.y        = '0;
        if (ang_sum > ANG_QUARTER)
        begin
            d3_next.x = -x0_ext;
            d3_next.z = ang_ext - Z_HALF;
        end
        else if (ang_sum < ANG_NEG_QUARTER)
        begin
            d3_next.x = -x0_ext;
            d3_next.z = ang_ext + Z_HALF;
        end
        else
        begin
            d3_next.x = x0_ext;
            d3_next.z = ang_ext;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg    <= sample_index;
            q0_reg    <= quot_prod[IDX_W+MOD_RECIP_W-1:MOD_SHIFT];
            rk0_reg   <= rk0_next;
            kept0_reg <= range_finite && (range_value != '0);
            end0_reg  <= scan_end_in;

            idx1_reg  <= idx1_next;
            x01_reg   <= x0_sum[RK_W:GAIN_FRAC-GUARD_BITS];
            kept1_reg <= kept0_reg;
            end1_reg  <= end0_reg;

            prod2_reg <= ang_prod[ANG_W-1:0];
            x02_reg   <= x01_reg;
            kept2_reg <= kept1_reg;
            end2_reg  <= end1_reg;

            d3_reg    <= d3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

// ===== rtl/core/scp_cordic_stage.sv =====
// ============================================================================
// scp_cordic_stage
// One registered rotation-mode CORDIC iteration with a fixed shift.
// ============================================================================
module scp_cordic_stage
    import scp_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  cordic_t in_data,
    output logic    out_valid,
    output cordic_t out_data
);

    localparam logic signed [Z_W-1:0] ATAN =
        $signed({{(Z_W-ANG_W){1'b0}}, atan_turn(STAGE)});

    logic                   valid_reg;
    cordic_t                data_reg;
    cordic_t                data_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    // Rotate toward zero residual angle; shifts are arithmetic.
    assign dx = in_data.y >>> STAGE;
    assign dy = in_data.x >>> STAGE;

    always_comb
    begin
        data_next.kept     = in_data.kept;
        data_next.scan_end = in_data.scan_end;
        if (!in_data.z[Z_W-1])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN;
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/scp_finish.sv =====
// ============================================================================
// scp_finish
// Output register: round off the guard bits, saturate to Q14.10 and zero the
// coordinates of discarded samples.
// ============================================================================
module scp_finish
    import scp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  cordic_t                in_data,
    output logic                   out_valid,
    output logic signed [OUT_W-1:0] point_x,
    output logic signed [OUT_W-1:0] point_y,
    output logic                   point_kept,
    output logic                   scan_end_out
);

    localparam logic signed [XY_W-1:0] ROUND_HALF = XY_W'(1 << (GUARD_BITS - 1));
    localparam logic signed [XY_W-1:0] SAT_MAX = XY_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [XY_W-1:0] SAT_MIN = -XY_W'(1 << (OUT_W - 1));

    logic                    valid_reg;
    logic signed [OUT_W-1:0] x_reg;
    logic signed [OUT_W-1:0] y_reg;
    logic                    kept_reg;
    logic                    end_reg;
    logic signed [OUT_W-1:0] x_next;
    logic signed [OUT_W-1:0] y_next;

    // Round half up, drop the guard bits, then clamp.
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] s;
        logic signed [OUT_W-1:0] r;
        s = (v + ROUND_HALF) >>> GUARD_BITS;
        if (s > SAT_MAX)
        begin
            r = SAT_MAX[OUT_W-1:0];
        end
        else if (s < SAT_MIN)
        begin
            r = SAT_MIN[OUT_W-1:0];
        end
        else
        begin
            r = s[OUT_W-1:0];
        end
        return r;
    endfunction

    assign x_next = in_data.kept ? round_sat(in_data.x) : '0;
    assign y_next = in_data.kept ? round_sat(in_data.y) : '0;

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            kept_reg <= in_data.kept;
            end_reg  <= in_data.scan_end;
        end
    end

    assign out_valid    = valid_reg;
    assign point_x      = x_reg;
    assign point_y      = y_reg;
    assign point_kept   = kept_reg;
    assign scan_end_out = end_reg;

endmodule

// ===== rtl/core/scan_polar_to_cartesian.sv =====
// Path from input transfer to result: four front stages, one register per CORDIC
// iteration and the output register.
// Throughput: one sample per cycle; the whole pipeline advances together and
// holds while a valid output is stalled; in_stall = out_stall && out_valid.
// Reset clears all valid bits and sets start_angle and angle_step to zero.
// ============================================================================
// scan_polar_to_cartesian
// Converts a laser-scan range sample to a planar point with a pipelined
// gain-compensated CORDIC.
// ============================================================================
module scan_polar_to_cartesian
    import scp_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Input channel.
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [IDX_W-1:0]        sample_index,
    input  logic [RANGE_W-1:0]      range_value,
    input  logic                    range_finite,
    input  logic                    scan_end_in,
    // Output channel.
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] point_x,
    output logic signed [OUT_W-1:0] point_y,
    output logic                    point_kept,
    output logic                    scan_end_out,
    // Configuration write channel.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ANG_W-1:0]        cfg_data
);

    logic             start_angle_reg;
    logic [ANG_W-1:0] start_angle_q;
    logic [ANG_W-1:0] angle_step_q;
    logic             advance;
    logic             stg_valid [CORDIC_STAGES+1];
    cordic_t          stg_data  [CORDIC_STAGES+1];

    // Configuration registers; writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_q   <= '0;
            angle_step_q    <= '0;
            start_angle_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_ANGLE:
                begin
                    start_angle_q   <= cfg_data;
                    start_angle_reg <= 1'b1;
                end
                REG_ANGLE_STEP:
                begin
                    angle_step_q <= cfg_data;
                end
                default:
                begin
                    start_angle_q <= start_angle_q;
                end
            endcase
        end
    end

    // The pipeline moves unless a finished result is held at the output.
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    scp_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .in_valid     (in_valid),
        .sample_index (sample_index),
        .range_value  (range_value),
        .range_finite (range_finite),
        .scan_end_in  (scan_end_in),
        .start_angle  (start_angle_q),
        .angle_step   (angle_step_q),
        .out_valid    (stg_valid[0]),
        .out_data     (stg_data[0])
    );

    // One registered iteration per CORDIC step.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        scp_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (stg_valid[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    scp_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .in_valid     (stg_valid[CORDIC_STAGES]),
        .in_data      (stg_data[CORDIC_STAGES]),
        .out_valid    (out_valid),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_kept   (point_kept),
        .scan_end_out (scan_end_out)
    );

    // A discarded sample always reports the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !point_kept) |-> (point_x == '0 && point_y == '0))
        else $error("discarded point has nonzero coordinates");

    // An output transfer frees the input side in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |-> !in_stall)
        else $error("input stalled while output drains");

    // A valid item leaving the last iteration reaches the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stg_valid[CORDIC_STAGES]) |=> out_valid)
        else $error("item lost between CORDIC and output register");

    // Start angle register is only marked written by a write to its index.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(start_angle_reg) |-> $past(cfg_valid && cfg_index == REG_START_ANGLE))
        else $error("start angle changed without a write");

endmodule

// ===== sim/point_check_pkg.sv =====
// ============================================================================
// point_check_pkg
// Expected-point computation and result checking for the scan
// polar-to-Cartesian converter testbench.
// ============================================================================
package point_check_pkg;

    import scp_pkg::*;

    // Number of CORDIC rotations that the testbench builds the block with.
    localparam int ROTATIONS = 16;

    // Fixed-point constants of the conversion.
    localparam longint LIMIT_GAIN_Q30 = 64'h26DD3B6A;
    localparam int     FRAC_GUARD     = 16;
    localparam longint TURN_QUARTER   = 64'h4000_0000;
    localparam longint TURN_HALF      = 64'h8000_0000;
    localparam longint COORD_HI       = 64'd16777215;
    localparam longint COORD_LO       = -64'd16777216;

    // Arc-tangent of 2^-i in binary angle units, rounded to nearest.
    localparam longint ARCTAN_BAU [ROTATIONS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    // One range sample as it enters the block.
    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [RANGE_W-1:0] distance;
        logic               finite;
        logic               last;
    } sample_t;

    // One Cartesian point as it leaves the block.
    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    kept;
        logic                    last;
    } point_t;

    class point_scoreboard;

        logic [ANG_W-1:0] start_angle;
        logic [ANG_W-1:0] angle_step;
        point_t           awaited_points[$];
        int               mismatches;
        int               checked;
        int               kept_count;
        int               dropped_count;
        int               scan_ends;

        function new();
            start_angle   = '0;
            angle_step    = '0;
            mismatches    = 0;
            checked       = 0;
            kept_count    = 0;
            dropped_count = 0;
            scan_ends     = 0;
        endfunction

        // Track the angle registers; unknown indexes leave them unchanged.
        function void write_reg(input logic [CFG_IDX_W-1:0] which,
                                input logic [ANG_W-1:0] value);
            case (which)
                REG_START_ANGLE: start_angle = value;
                REG_ANGLE_STEP:  angle_step  = value;
                default:         ;
            endcase
        endfunction

        // Round away the guard bits (half up) and clamp to the output range.
        function logic signed [OUT_W-1:0] round_coord(input longint v);
            longint t;
            t = (v + (64'sd1 <<< (FRAC_GUARD - 1))) >>> FRAC_GUARD;
            if (t > COORD_HI)
                t = COORD_HI;
            if (t < COORD_LO)
                t = COORD_LO;
            return t[OUT_W-1:0];
        endfunction

        // Rotate the gain-compensated range to the sample angle.
        function point_t polar_to_point(input sample_t s);
            point_t           p;
            logic [IDX_W-1:0] pos;
            logic [ANG_W-1:0] ang;
            longint           x;
            longint           y;
            longint           z;
            longint           dx;
            longint           dy;
            p.kept = s.finite && (s.distance != '0);
            p.last = s.last;
            p.x    = '0;
            p.y    = '0;
            if (p.kept)
            begin
                pos = IDX_W'(s.index % MAX_SAMPLES);
                ang = start_angle + {{(ANG_W - IDX_W){1'b0}}, pos} * angle_step;
                z   = $signed(ang);
                x   = (longint'(s.distance) * LIMIT_GAIN_Q30 + 64'sd8192) >>> 14;
                y   = 0;
                // Angles beyond a quarter turn start from the opposite side.
                if (z > TURN_QUARTER)
                begin
                    x = -x;
                    z = z - TURN_HALF;
                end
                else if (z < -TURN_QUARTER)
                begin
                    x = -x;
                    z = z + TURN_HALF;
                end
                for (int i = 0; i < ROTATIONS; i++)
                begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (z >= 0)
                    begin
                        x = x - dx;
                        y = y + dy;
                        z = z - ARCTAN_BAU[i];
                    end
                    else
                    begin
                        x = x + dx;
                        y = y - dy;
                        z = z + ARCTAN_BAU[i];
                    end
                end
                p.x = round_coord(x);
                p.y = round_coord(y);
            end
            return p;
        endfunction

        function void note_sample(input sample_t s);
            awaited_points.push_back(polar_to_point(s));
        endfunction

        // Printing stops after the first few dozen so a broken build stays readable.
        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH: %s", what);
        endtask

        task check_point(input logic signed [OUT_W-1:0] x,
                         input logic signed [OUT_W-1:0] y,
                         input logic kept,
                         input logic last);
            point_t want;
            if (awaited_points.size() == 0)
            begin
                report_mismatch($sformatf("point with no sample pending: x=%0d y=%0d", x, y));
                return;
            end
            want = awaited_points.pop_front();
            if (kept !== want.kept)
                report_mismatch($sformatf("point %0d kept flag: expected %0b, got %0b",
                                          checked, want.kept, kept));
            if (last !== want.last)
                report_mismatch($sformatf("point %0d scan end: expected %0b, got %0b",
                                          checked, want.last, last));
            if (x !== want.x)
                report_mismatch($sformatf("point %0d x: expected %0d, got %0d",
                                          checked, want.x, x));
            if (y !== want.y)
                report_mismatch($sformatf("point %0d y: expected %0d, got %0d",
                                          checked, want.y, y));
            checked++;
            if (want.kept)
                kept_count++;
            else
                dropped_count++;
            if (want.last)
                scan_ends++;
        endtask

    endclass

endpackage

// ===== sim/tb_scan_polar_to_cartesian.sv =====
// ============================================================================
// tb_scan_polar_to_cartesian
// Streams range samples through the converter under several angle settings,
// with random gaps on the input and random stalls on the output, and checks
// every point against an independently computed CORDIC result.
// ============================================================================
module tb_scan_polar_to_cartesian;

    timeunit 1ns;
    timeprecision 1ps;

    import scp_pkg::*;
    import point_check_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int PIPE_LATENCY = ROTATIONS + 5;
    localparam int PHASE_ITEMS  = 125;
    localparam int PHASES       = 6;

    // Register indexes that the block does not implement.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [IDX_W-1:0]        sample_index = '0;
    logic [RANGE_W-1:0]      range_value = '0;
    logic                    range_finite = 1'b0;
    logic                    scan_end_in = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic                    point_kept;
    logic                    scan_end_out;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [ANG_W-1:0]        cfg_data = '0;

    point_scoreboard sb = new();
    logic            no_gaps = 1'b0;
    int              settings_count = 0;

    scan_polar_to_cartesian #(
        .CORDIC_STAGES (ROTATIONS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_index (sample_index),
        .range_value  (range_value),
        .range_finite (range_finite),
        .scan_end_in  (scan_end_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_kept   (point_kept),
        .scan_end_out (scan_end_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Idle cycles before the next transfer on either side.
    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, 3));
    endfunction

    function automatic sample_t make_sample(input logic [IDX_W-1:0] idx,
                                            input logic [RANGE_W-1:0] distance,
                                            input logic fin,
                                            input logic last);
        sample_t s;
        s.index    = idx;
        s.distance = distance;
        s.finite   = fin;
        s.last     = last;
        return s;
    endfunction

    // Mostly full-width ranges, with zero, maximum and short ranges mixed in.
    function automatic logic [RANGE_W-1:0] draw_distance();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else if (pick < 6)
            return RANGE_W'($urandom_range(1, 1023));
        return RANGE_W'($urandom);
    endfunction

    // Present one sample and hold it until the transfer.
    task automatic send_sample(input sample_t s);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_index <= s.index;
        range_value  <= s.distance;
        range_finite <= s.finite;
        scan_end_in  <= s.last;
        do @(posedge clk); while (in_stall);
        sb.note_sample(s);
    endtask

    // Stop sending until every pending point has come out, then wait a bit more.
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        while (sb.awaited_points.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Write both angle registers, then an unimplemented index that must be ignored.
    task automatic set_angles(input logic [ANG_W-1:0] start, input logic [ANG_W-1:0] step);
        logic [CFG_IDX_W-1:0] which [3];
        logic [ANG_W-1:0]     value [3];
        which[0] = REG_START_ANGLE;
        value[0] = start;
        which[1] = REG_ANGLE_STEP;
        value[1] = step;
        which[2] = $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
        value[2] = $urandom;
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= which[k];
            cfg_data  <= value[k];
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(which[k], value[k]);
        end
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // Random scans: mostly consecutive indexes ending in a scan end mark,
    // with some scans of scattered indexes and random end marks.
    task automatic run_scans(input int items);
        int               left;
        int               len;
        int               pause_at;
        logic             scattered;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] idx;
        logic             last;
        left     = items;
        pause_at = $urandom_range(10, items - 10);
        while (left > 0)
        begin
            len       = $urandom_range(1, 64);
            scattered = ($urandom_range(0, 7) == 0);
            base      = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : '0;
            no_gaps   = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < len && left > 0; k++)
            begin
                idx  = scattered ? IDX_W'($urandom) : base + IDX_W'(k);
                last = scattered ? 1'($urandom) : (k == len - 1 || left == 1);
                send_sample(make_sample(idx, draw_distance(),
                                        $urandom_range(0, 15) != 0, last));
                left--;
                if (left == pause_at)
                    drain(0);
            end
        end
        no_gaps = 1'b0;
    endtask

    // Result side: random stall before each transfer.
    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = draw_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // Check every point transfer.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_point(point_x, point_y, point_kept, scan_end_out);
    end

    // Safety net against a hung handshake.
    initial
    begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        logic [ANG_W-1:0] phase_start [PHASES];
        logic [ANG_W-1:0] phase_step [PHASES];
        phase_start = '{32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, $urandom, $urandom};
        phase_step  = '{32'h0010_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        $urandom, $urandom};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset angles: tiny and full ranges, zero range, non-finite range.
        send_sample(make_sample(12'd0, 24'd1, 1'b1, 1'b0));
        send_sample(make_sample(12'd4095, 24'hFF_FFFF, 1'b1, 1'b0));
        send_sample(make_sample(12'd5, 24'd0, 1'b1, 1'b0));
        send_sample(make_sample(12'd7, 24'hAB_CDEF, 1'b0, 1'b1));
        drain(PIPE_LATENCY);

        // One turn per 4096 samples: hit the quarter and half turn boundaries.
        set_angles(32'h0, 32'h0010_0000);
        send_sample(make_sample(12'd1024, 24'hFF_FFFF, 1'b1, 1'b0));
        send_sample(make_sample(12'd1025, 24'h00_0400, 1'b1, 1'b0));
        send_sample(make_sample(12'd1023, 24'h80_0000, 1'b1, 1'b0));
        send_sample(make_sample(12'd2048, 24'hFF_FFFF, 1'b1, 1'b0));
        send_sample(make_sample(12'd2047, 24'h12_3456, 1'b1, 1'b0));
        send_sample(make_sample(12'd2049, 24'h65_4321, 1'b1, 1'b0));
        send_sample(make_sample(12'd3072, 24'hFF_FFFF, 1'b1, 1'b0));
        send_sample(make_sample(12'd3071, 24'h00_0001, 1'b1, 1'b0));
        send_sample(make_sample(12'd3073, 24'h7F_FFFF, 1'b1, 1'b0));
        send_sample(make_sample(12'd512, 24'hFF_FFFF, 1'b1, 1'b0));
        send_sample(make_sample(12'd4095, 24'hFF_FFFF, 1'b0, 1'b1));
        send_sample(make_sample(12'd0, 24'h80_0000, 1'b1, 1'b1));
        drain(PIPE_LATENCY);

        // Extreme register values.
        set_angles(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(make_sample(12'd0, 24'h12_3456, 1'b1, 1'b0));
        send_sample(make_sample(12'd1, 24'hFF_FFFF, 1'b1, 1'b0));
        send_sample(make_sample(12'd4095, 24'h00_0400, 1'b1, 1'b1));
        drain(PIPE_LATENCY);
        set_angles(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(make_sample(12'd0, 24'hFF_FFFF, 1'b1, 1'b0));
        send_sample(make_sample(12'd1, 24'h00_0400, 1'b1, 1'b0));
        send_sample(make_sample(12'd4095, 24'hAA_AAAA, 1'b1, 1'b1));
        drain(PIPE_LATENCY);

        // Random scans under several angle settings.
        for (int p = 0; p < PHASES; p++)
        begin
            set_angles(phase_start[p], phase_step[p]);
            run_scans(PHASE_ITEMS);
            drain(PIPE_LATENCY);
        end

        drain(2 * PIPE_LATENCY);
        if (sb.awaited_points.size() != 0)
            sb.report_mismatch($sformatf("%0d points never came out",
                                         sb.awaited_points.size()));

        $display("Checked %0d points (%0d kept, %0d discarded, %0d scan ends)",
                 sb.checked, sb.kept_count, sb.dropped_count, sb.scan_ends);
        $display("across %0d angle register settings.", settings_count);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/scp_pkg.sv
rtl/core/scp_prep.sv
rtl/core/scp_cordic_stage.sv
rtl/core/scp_finish.sv
rtl/core/scan_polar_to_cartesian.sv
sim/point_check_pkg.sv
sim/tb_scan_polar_to_cartesian.sv
